>>> rtl/humidity_temperature_frame_decoder_assert.svh
// Assertion macros shared by the decoder's modules.
`ifndef HUMIDITY_TEMPERATURE_FRAME_DECODER_ASSERT_SVH
`define HUMIDITY_TEMPERATURE_FRAME_DECODER_ASSERT_SVH
`ifndef SYNTHESIS
`define HTFD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define HTFD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define HTFD_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define HTFD_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

>>> rtl/htfd_pkg.sv
package htfd_pkg;

    localparam logic [7:0] CRC_INIT   = 8'hFF;
    localparam logic [7:0] CRC_POLY   = 8'h31;
    localparam logic [2:0] LAST_BYTE  = 3'd6;
    localparam int         RAW_W      = 20;
    localparam int         HUM_W      = 14;
    localparam int         TEMP_W     = 15;
    localparam int         HUM_PROD_W = 34;
    localparam int         TMP_PROD_W = 35;
    localparam logic [HUM_PROD_W-1:0] HUM_SCALE  = HUM_PROD_W'(10000);
    localparam logic [TMP_PROD_W-1:0] TEMP_SCALE = TMP_PROD_W'(20000);
    localparam logic [TEMP_W:0]       TEMP_OFFSET = (TEMP_W + 1)'(5000);

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_BUSY    = 2'd1,
        STATUS_CRC_ERR = 2'd2
    } frame_status_t;

    // One complete frame as handed from the front end to the back end.
    typedef struct packed {
        logic             busy;
        logic             crc_ok;
        logic [RAW_W-1:0] hum_raw;
        logic [RAW_W-1:0] temp_raw;
    } frame_rec_t;

    // CRC-8, MSB first, one whole byte per call.
    function automatic logic [7:0] crc8_byte(input logic [7:0] acc, input logic [7:0] b);
        logic [7:0] v;
        v = acc ^ b;
        for (int k = 0; k < 8; k++) begin
            v = v[7] ? ({v[6:0], 1'b0} ^ CRC_POLY) : {v[6:0], 1'b0};
        end
        return v;
    endfunction

endpackage

>>> rtl/humidity_temperature_frame_decoder.sv
// After the CRC byte is accepted, the result word passes through the frame queue, stage one and the output register.
// Throughput: one byte per cycle; s_tready falls only while the frame queue is full.
// The queue of QUEUE_DEPTH frames decouples the byte front end from the scaling pipeline.
// Reset (aresetn low, synchronous) clears the byte count, CRC, queue and pipeline valids.
module humidity_temperature_frame_decoder
    import htfd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // rx_byte
    input  logic [0:0]  s_tuser,   // frame_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // humidity_raw, temperature_raw, humidity_centi,
                                   // temperature_centi, zero pad
    output logic [1:0]  m_tuser    // frame_status
);

    logic                      q_full;
    logic                      push_valid;
    frame_rec_t                push_rec;
    logic                      pop;
    logic                      pop_valid;
    frame_rec_t                pop_rec;
    frame_status_t             out_status;
    logic [RAW_W-1:0]          hum_raw;
    logic [RAW_W-1:0]          temp_raw;
    logic [HUM_W-1:0]          hum_centi;
    logic signed [TEMP_W-1:0]  temp_centi;

    htfd_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_byte    (s_tdata),
        .in_start   (s_tuser[0]),
        .in_ready   (s_tready),
        .q_full     (q_full),
        .push_valid (push_valid),
        .push_rec   (push_rec)
    );

    htfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_rec   (push_rec),
        .full       (q_full),
        .pop        (pop),
        .pop_valid  (pop_valid),
        .pop_rec    (pop_rec)
    );

    htfd_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .pop_valid      (pop_valid),
        .pop_rec        (pop_rec),
        .pop            (pop),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_status     (out_status),
        .out_hum_raw    (hum_raw),
        .out_temp_raw   (temp_raw),
        .out_hum_centi  (hum_centi),
        .out_temp_centi (temp_centi)
    );

    assign m_tdata = {3'b000, temp_centi, hum_centi, temp_raw, hum_raw};
    assign m_tuser = out_status;

endmodule

>>> rtl/htfd_front.sv
module htfd_front
    import htfd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    input  logic [7:0] in_byte,
    input  logic       in_start,
    output logic       in_ready,
    input  logic       q_full,
    output logic       push_valid,
    output frame_rec_t push_rec
);

    logic [2:0]  count_reg, count_next;
    logic [7:0]  crc_reg, crc_next;
    logic [39:0] payload_reg, payload_next;
    logic        busy_reg, busy_next;
    logic [2:0]  pos;
    logic        accept;
    logic        is_first;
    logic        is_last;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign pos      = in_start ? 3'd0 : count_reg;
    assign is_first = (pos == 3'd0) || (pos > LAST_BYTE);
    assign is_last  = !is_first && (pos == LAST_BYTE);

    always_comb begin
        count_next   = count_reg;
        crc_next     = crc_reg;
        payload_next = payload_reg;
        busy_next    = busy_reg;
        if (accept) begin
            if (is_first) begin
                busy_next    = in_byte[7];
                crc_next     = crc8_byte(CRC_INIT, in_byte);
                payload_next = '0;
                count_next   = 3'd1;
            end else if (is_last) begin
                crc_next   = CRC_INIT;
                count_next = 3'd0;
            end else begin
                crc_next     = crc8_byte(crc_reg, in_byte);
                payload_next = {payload_reg[31:0], in_byte};
                count_next   = pos + 3'd1;
            end
        end
    end

    assign push_valid        = accept && is_last;
    assign push_rec.busy     = busy_reg;
    assign push_rec.crc_ok   = (crc_reg == in_byte);
    assign push_rec.hum_raw  = payload_reg[39:20];
    assign push_rec.temp_raw = payload_reg[19:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 3'd0;
            crc_reg   <= CRC_INIT;
            busy_reg  <= 1'b0;
        end else begin
            count_reg <= count_next;
            crc_reg   <= crc_next;
            busy_reg  <= busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        payload_reg <= payload_next;
    end

endmodule

>>> rtl/htfd_queue.sv
`include "humidity_temperature_frame_decoder_assert.svh"
module htfd_queue
    import htfd_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push_valid,
    input  frame_rec_t push_rec,
    output logic       full,
    input  logic       pop,
    output logic       pop_valid,
    output frame_rec_t pop_rec
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    frame_rec_t      mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_push;
    logic            do_pop;

    assign full      = (count_reg == CW'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_rec   = mem_reg[rd_ptr_reg];
    assign do_push   = push_valid && !full;
    assign do_pop    = pop && pop_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        count_next = count_reg + CW'(do_push) - CW'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_rec;
        end
    end

    `HTFD_ASSERT_IMP(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CW'(DEPTH))
    `HTFD_ASSERT_IMP(a_no_push_full, aclk, aresetn, push_valid, !full)
    `HTFD_ASSERT_NEXT(a_count_up, aclk, aresetn, do_push && !do_pop, count_reg == $past(count_reg) + CW'(1))

endmodule

>>> rtl/htfd_back.sv
`include "humidity_temperature_frame_decoder_assert.svh"
module htfd_back
    import htfd_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     pop_valid,
    input  frame_rec_t               pop_rec,
    output logic                     pop,
    output logic                     out_valid,
    input  logic                     out_ready,
    output frame_status_t            out_status,
    output logic [RAW_W-1:0]         out_hum_raw,
    output logic [RAW_W-1:0]         out_temp_raw,
    output logic [HUM_W-1:0]         out_hum_centi,
    output logic signed [TEMP_W-1:0] out_temp_centi
);

    // Stage one: status decision and the two constant multiplications.
    logic                  s1_valid_reg;
    frame_status_t         s1_status_reg, s1_status_next;
    logic [RAW_W-1:0]      s1_hum_raw_reg;
    logic [RAW_W-1:0]      s1_temp_raw_reg;
    logic [HUM_PROD_W-1:0] s1_hum_prod_reg;
    logic [TMP_PROD_W-1:0] s1_temp_prod_reg;

    // Stage two: output register.
    logic                     out_valid_reg;
    frame_status_t            out_status_reg;
    logic [RAW_W-1:0]         out_hum_raw_reg;
    logic [RAW_W-1:0]         out_temp_raw_reg;
    logic [HUM_W-1:0]         out_hum_centi_reg, out_hum_centi_next;
    logic [TEMP_W-1:0]        out_temp_centi_reg, out_temp_centi_next;
    logic [TEMP_W:0]          temp_diff;

    logic out_en;
    logic s1_en;

    assign out_en = !out_valid_reg || out_ready;
    assign s1_en  = !s1_valid_reg || out_en;
    assign pop    = pop_valid && s1_en;

    always_comb begin
        if (pop_rec.busy) begin
            s1_status_next = STATUS_BUSY;
        end else if (!pop_rec.crc_ok) begin
            s1_status_next = STATUS_CRC_ERR;
        end else begin
            s1_status_next = STATUS_OK;
        end
    end

    assign temp_diff = {1'b0, s1_temp_prod_reg[TMP_PROD_W-1:RAW_W]} - TEMP_OFFSET;

    always_comb begin
        if (s1_status_reg == STATUS_OK) begin
            out_hum_centi_next  = s1_hum_prod_reg[HUM_PROD_W-1:RAW_W];
            out_temp_centi_next = temp_diff[TEMP_W-1:0];
        end else begin
            out_hum_centi_next  = '0;
            out_temp_centi_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s1_en) begin
                s1_valid_reg <= pop_valid;
            end
            if (out_en) begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            s1_status_reg    <= s1_status_next;
            s1_hum_raw_reg   <= pop_rec.hum_raw;
            s1_temp_raw_reg  <= pop_rec.temp_raw;
            s1_hum_prod_reg  <= HUM_PROD_W'(pop_rec.hum_raw) * HUM_SCALE;
            s1_temp_prod_reg <= TMP_PROD_W'(pop_rec.temp_raw) * TEMP_SCALE;
        end
        if (out_en && s1_valid_reg) begin
            out_status_reg     <= s1_status_reg;
            out_hum_raw_reg    <= s1_hum_raw_reg;
            out_temp_raw_reg   <= s1_temp_raw_reg;
            out_hum_centi_reg  <= out_hum_centi_next;
            out_temp_centi_reg <= out_temp_centi_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_status     = out_status_reg;
    assign out_hum_raw    = out_hum_raw_reg;
    assign out_temp_raw   = out_temp_raw_reg;
    assign out_hum_centi  = out_hum_centi_reg;
    assign out_temp_centi = signed'(out_temp_centi_reg);

    `HTFD_ASSERT_IMP(a_bad_zero, aclk, aresetn, out_valid_reg && (out_status_reg != STATUS_OK), (out_hum_centi_reg == '0) && (out_temp_centi_reg == '0))
    `HTFD_ASSERT_IMP(a_hum_range, aclk, aresetn, out_valid_reg, out_hum_centi_reg <= HUM_W'(9999))
    `HTFD_ASSERT_NEXT(a_s1_hold, aclk, aresetn, s1_valid_reg && !s1_en, s1_valid_reg)

endmodule
